FILE: design/wmmf_pkg.sv
// Shared types and constants of the sliding window min/max filter.
`default_nettype none
package wmmf_pkg;

  // Pixel and field widths
  localparam int PixW      = 8;
  localparam int CfgW      = 12;
  localparam int DimW      = CfgW + 1;   // holds a clamped width or height
  localparam int RowW      = 11;
  localparam int OutColW   = 11;

  // Stream packing
  localparam int InTdataW  = 8;
  localparam int OutTdataW = 40;         // max, min, row, col = 38 bits, padded

  // Frame height never exceeds this
  localparam int HeightLimit = 2048;

  // Configuration reset values
  localparam logic [CfgW-1:0] WidthReset  = CfgW'(1280);
  localparam logic [CfgW-1:0] HeightReset = CfgW'(720);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PixW-1:0] pix_t;

endpackage
`default_nettype wire

FILE: design/wmmf_row_mem.sv
// Row store memory: one word per column, registered read port.
`default_nettype none
module wmmf_row_mem #(
  parameter int Depth = 2048,
  parameter int Width = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: design/wmmf_reduce.sv
// Balanced compare tree: maximum of one vector and minimum of another.
`default_nettype none
module wmmf_reduce #(
  parameter int N = 7
) (
  input  wire logic [N-1:0][wmmf_pkg::PixW-1:0] max_data_i,
  input  wire logic [N-1:0][wmmf_pkg::PixW-1:0] min_data_i,
  output wmmf_pkg::pix_t                        max_o,
  output wmmf_pkg::pix_t                        min_o
);
  import wmmf_pkg::*;

  localparam int Leaves = 1 << $clog2(N);
  localparam int Nodes  = 2 * Leaves - 1;

  pix_t max_tree [Nodes];
  pix_t min_tree [Nodes];

  // Heap layout: node i has children 2i+1 and 2i+2, leaves at the end.
  // Unused leaves hold the neutral value of each reduction.
  always_comb begin
    for (int j = 0; j < Leaves; j++) begin
      if (j < N) begin
        max_tree[Leaves-1+j] = max_data_i[j];
        min_tree[Leaves-1+j] = min_data_i[j];
      end else begin
        max_tree[Leaves-1+j] = '0;
        min_tree[Leaves-1+j] = '1;
      end
    end
    for (int i = Leaves - 2; i >= 0; i--) begin
      max_tree[i] = (max_tree[2*i+1] > max_tree[2*i+2]) ? max_tree[2*i+1] : max_tree[2*i+2];
      min_tree[i] = (min_tree[2*i+1] < min_tree[2*i+2]) ? min_tree[2*i+1] : min_tree[2*i+2];
    end
  end

  assign max_o = max_tree[0];
  assign min_o = min_tree[0];

endmodule
`default_nettype wire

FILE: design/window_min_max_filter_unit.sv
// Top level of the streaming 2-D sliding window min/max filter.
//
// Takes one 8-bit raster pixel per clock and returns one result per pixel: the
// maximum and minimum over the (2*WIN_RADIUS+1)-square window whose centre lies
// WIN_RADIUS rows and columns behind, with the centre position and a flag that
// is set only where the whole window lies inside the image (other results carry
// zeros). Throughput is one pixel per clock unless m_axis_tready stalls the
// output: the pixel is registered while its column word (the last 2*WIN_RADIUS
// rows at that column) is read from a single-port-read row memory, and the
// column and window reductions feed the output register, which also writes the
// updated column word back. Back-to-back pixels on the same column are
// forwarded. The row memory has no clearing pass; rows not yet written in a
// frame only reach results that are flagged invalid. The start-of-frame flag
// (tuser) restarts the raster.
`default_nettype none
module window_min_max_filter_unit #(
  parameter int WIN_RADIUS = 3,
  parameter int MAX_WIDTH  = 2048
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Pixel stream in
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [wmmf_pkg::InTdataW-1:0]      s_axis_tdata,  // [7:0] pixel
  input  wire logic                               s_axis_tuser,  // [0] sof
  // Result stream out
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [7:0] window_max, [15:8] window_min, [26:16] centre_row, [37:27] centre_col
  output logic      [wmmf_pkg::OutTdataW-1:0]     m_axis_tdata,
  output logic                                    m_axis_tuser,  // [0] valid_res
  // Configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_idx_i,
  input  wire logic [wmmf_pkg::CfgW-1:0]          cfg_data_i
);
  import wmmf_pkg::*;

  localparam int Span     = 2 * WIN_RADIUS + 1;
  localparam int Rows     = 2 * WIN_RADIUS;
  localparam int WordW    = Rows * PixW;
  localparam int ColW     = $clog2(MAX_WIDTH);

  // Configuration registers
  logic [CfgW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default:          width_q  <= width_q;
      endcase
    end
  end

  // Clamped frame dimensions
  logic [DimW-1:0] width_eff, height_eff;

  always_comb begin
    if (width_q == '0) begin
      width_eff = DimW'(1);
    end else if (DimW'(width_q) > DimW'(MAX_WIDTH)) begin
      width_eff = DimW'(MAX_WIDTH);
    end else begin
      width_eff = DimW'(width_q);
    end
    if (height_q == '0) begin
      height_eff = DimW'(1);
    end else if (DimW'(height_q) > DimW'(HeightLimit)) begin
      height_eff = DimW'(HeightLimit);
    end else begin
      height_eff = DimW'(height_q);
    end
  end

  // Handshake and stage control
  logic s1_valid_q, out_valid_q;
  logic out_ready, s1_ready, s1_adv, in_acc;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s1_adv        = s1_valid_q && out_ready;
  assign s_axis_tready = s1_ready;
  assign in_acc        = s_axis_tvalid && s1_ready;

  // Raster position of the accepted pixel
  logic [ColW-1:0] col_q, col_d, col_cur;
  logic [RowW-1:0] row_q, row_d, row_cur;
  logic            res_valid;
  logic [DimW-1:0] col_ext, row_ext;

  assign col_cur = s_axis_tuser ? '0 : col_q;
  assign row_cur = s_axis_tuser ? '0 : row_q;
  assign col_ext = DimW'(col_cur);
  assign row_ext = DimW'(row_cur);

  always_comb begin
    res_valid = (row_ext >= DimW'(Rows)) && (col_ext >= DimW'(Rows))
             && (row_ext < height_eff) && (col_ext < width_eff);
    if (col_ext + DimW'(1) >= width_eff) begin
      col_d = '0;
      row_d = (row_ext + DimW'(1) >= height_eff) ? '0 : row_cur + RowW'(1);
    end else begin
      col_d = col_cur + ColW'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // First stage registers
  pix_t                s1_px_q;
  logic [ColW-1:0]     s1_col_q;
  logic                s1_res_q;
  logic [RowW-1:0]     s1_crow_q;
  logic [OutColW-1:0]  s1_ccol_q;
  logic                fwd_q;
  logic [WordW-1:0]    fwd_word_q;
  logic [WordW-1:0]    mem_rdata, rd_word, wr_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      // Previous pixel on the same column writes as this one reads
      if (in_acc) begin
        fwd_q <= s1_adv && (s1_col_q == col_cur);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q    <= s_axis_tdata[PixW-1:0];
      s1_col_q   <= col_cur;
      s1_res_q   <= res_valid;
      s1_crow_q  <= RowW'(row_ext - DimW'(WIN_RADIUS));
      s1_ccol_q  <= OutColW'(col_ext - DimW'(WIN_RADIUS));
      fwd_word_q <= wr_word;
    end
  end

  // Column word: oldest row in the low byte, the new pixel enters at the top
  assign rd_word = fwd_q ? fwd_word_q : mem_rdata;
  assign wr_word = {s1_px_q, rd_word[WordW-1:PixW]};

  wmmf_row_mem #(
    .Depth (MAX_WIDTH),
    .Width (WordW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (wr_word),
    .re_i    (in_acc),
    .raddr_i (col_cur),
    .rdata_o (mem_rdata)
  );

  // Vertical reduction over the stored rows and the new pixel
  logic [Span-1:0][PixW-1:0] col_vec;
  pix_t                      col_max, col_min;

  assign col_vec = {rd_word, s1_px_q};

  wmmf_reduce #(
    .N (Span)
  ) u_col_reduce (
    .max_data_i (col_vec),
    .min_data_i (col_vec),
    .max_o      (col_max),
    .min_o      (col_min)
  );

  // Column windows, oldest first
  pix_t win_max_q [Span];
  pix_t win_min_q [Span];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Span; k++) begin
        win_max_q[k] <= '0;
        win_min_q[k] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < Span - 1; k++) begin
        win_max_q[k] <= win_max_q[k+1];
        win_min_q[k] <= win_min_q[k+1];
      end
      win_max_q[Span-1] <= col_max;
      win_min_q[Span-1] <= col_min;
    end
  end

  // Horizontal reduction over the window after the shift
  logic [Span-1:0][PixW-1:0] hmax_vec, hmin_vec;
  pix_t                      win_max, win_min;

  always_comb begin
    for (int k = 0; k < Span - 1; k++) begin
      hmax_vec[k] = win_max_q[k+1];
      hmin_vec[k] = win_min_q[k+1];
    end
    hmax_vec[Span-1] = col_max;
    hmin_vec[Span-1] = col_min;
  end

  wmmf_reduce #(
    .N (Span)
  ) u_win_reduce (
    .max_data_i (hmax_vec),
    .min_data_i (hmin_vec),
    .max_o      (win_max),
    .min_o      (win_min)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_res_q) begin
        m_axis_tdata <= {2'b00, s1_ccol_q, s1_crow_q, win_min, win_max};
      end else begin
        m_axis_tdata <= '0;
      end
      m_axis_tuser <= s1_res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule
`default_nettype wire
